### sv/mqd_pkg.sv
// shared types and constants for the mqtt packet deframer
`default_nettype none
package mqd_pkg;

    localparam int BYTE_W  = 8;
    localparam int ROLE_W  = 3;
    localparam int NIB_W   = 4;
    localparam int LEN_W   = 28;
    localparam int TLEN_W  = 16;
    localparam int LVL_W   = 4;
    localparam int MINL_W  = 5;

    localparam logic [MINL_W-1:0] MIN_LEVELS_RESET = 5'd3;
    localparam logic [BYTE_W-1:0] RC_UNKNOWN       = 8'hFF;
    localparam logic [BYTE_W-1:0] SLASH_CHAR       = 8'h2F;
    localparam logic [LVL_W-1:0]  LVL_MAX          = 4'hF;

    localparam logic [NIB_W-1:0] PKT_CONNACK = 4'd2;
    localparam logic [NIB_W-1:0] PKT_PUBLISH = 4'd3;

    localparam logic [ROLE_W-1:0] ROLE_TYPE      = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_LENGTH    = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_TOPIC_LEN = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_TOPIC     = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_PKT_ID    = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD   = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_OTHER     = 3'd6;
    localparam logic [ROLE_W-1:0] ROLE_DROPPED   = 3'd7;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_HALT   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [ROLE_W-1:0] role;
        logic [NIB_W-1:0]  packet_type;
        logic [NIB_W-1:0]  header_flags;
        logic [LEN_W-1:0]  body_length;
        logic [LEN_W-1:0]  body_index;
        logic [LVL_W-1:0]  topic_level;
        logic              last_of_packet;
        logic              publish_usable;
        logic [BYTE_W-1:0] connack_code;
        logic              connack_accepted;
        logic              length_error;
    } result_t;

endpackage
`default_nettype wire

### sv/mqd_in_stage.sv
// input register stage for received bytes
`default_nettype none
module mqd_in_stage
    import mqd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_rx_byte,
    input  wire logic              down_ready,
    output logic                   byte_valid,
    output logic [BYTE_W-1:0]      byte_data,
    output logic                   advance
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    assign advance    = valid_reg && down_ready;
    assign s_ready    = !valid_reg || down_ready;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_rx_byte;
        end
    end

endmodule
`default_nettype wire

### sv/mqd_decode.sv
// packet state and per-word tag decode
`default_nettype none
module mqd_decode
    import mqd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MINL_W-1:0] cfg_data,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] byte_data,
    output result_t                res
);

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   tf_reg, tf_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [1:0]          lcnt_reg, lcnt_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic [TLEN_W-1:0]   tlen_reg, tlen_next;
    logic [LVL_W-1:0]    slash_reg, slash_next;
    logic [BYTE_W-1:0]   rc_reg, rc_next;
    logic [MINL_W-1:0]   minl_reg;

    logic [LEN_W-1:0]    len_part;
    logic [LEN_W:0]      pos_inc;
    logic [TLEN_W:0]     topic_end;
    logic [TLEN_W+1:0]   id_end;
    logic [1:0]          qos;
    logic [MINL_W-1:0]   levels;
    logic                is_last;

    assign cfg_ready = 1'b1;

    always_comb begin
        unique case (lcnt_reg)
            2'd0: len_part = {21'd0, byte_data[6:0]};
            2'd1: len_part = {14'd0, byte_data[6:0], 7'd0};
            2'd2: len_part = {7'd0, byte_data[6:0], 14'd0};
            2'd3: len_part = {byte_data[6:0], 21'd0};
        endcase
    end

    assign pos_inc   = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign is_last   = pos_inc >= {1'b0, len_reg};
    assign topic_end = {1'b0, tlen_reg} + 17'd2;
    assign qos       = tf_reg[2:1];
    assign id_end    = {1'b0, topic_end} + ((qos != 2'd0) ? 18'd2 : 18'd0);

    always_comb begin
        phase_next = phase_reg;
        tf_next    = tf_reg;
        len_next   = len_reg;
        lcnt_next  = lcnt_reg;
        pos_next   = pos_reg;
        tlen_next  = tlen_reg;
        slash_next = slash_reg;
        rc_next    = rc_reg;
        res        = '0;
        levels     = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                tf_next    = byte_data;
                len_next   = '0;
                lcnt_next  = '0;
                pos_next   = '0;
                tlen_next  = '0;
                slash_next = '0;
                rc_next    = RC_UNKNOWN;
                phase_next = PH_LENGTH;
                res.role   = ROLE_TYPE;
            end
            PH_LENGTH: begin
                res.role = ROLE_LENGTH;
                len_next = len_reg | len_part;
                res.body_length = len_next;
                if (byte_data[7]) begin
                    if (lcnt_reg == 2'd3) begin
                        phase_next = PH_HALT;
                    end else begin
                        lcnt_next = lcnt_reg + 2'd1;
                    end
                end else if (len_next == '0) begin
                    res.last_of_packet = 1'b1;
                    if (tf_reg[7:4] == PKT_CONNACK) begin
                        res.connack_code = RC_UNKNOWN;
                    end
                    phase_next = PH_HEADER;
                end else begin
                    pos_next   = '0;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                res.body_length = len_reg;
                res.body_index  = pos_reg;
                if (tf_reg[7:4] == PKT_PUBLISH) begin
                    if (pos_reg == '0) begin
                        tlen_next = {byte_data, 8'd0};
                        res.role  = ROLE_TOPIC_LEN;
                    end else if (pos_reg == 28'd1) begin
                        tlen_next = {tlen_reg[15:8], byte_data};
                        res.role  = ROLE_TOPIC_LEN;
                    end else if (pos_reg < {11'd0, topic_end}) begin
                        res.role = ROLE_TOPIC;
                        if (byte_data == SLASH_CHAR && slash_reg != LVL_MAX) begin
                            slash_next = slash_reg + 4'd1;
                        end
                    end else if (pos_reg < {10'd0, id_end}) begin
                        res.role = ROLE_PKT_ID;
                    end else begin
                        res.role = ROLE_PAYLOAD;
                    end
                end else begin
                    res.role = ROLE_OTHER;
                    if (tf_reg[7:4] == PKT_CONNACK && pos_reg == 28'd1) begin
                        rc_next = byte_data;
                    end
                end
                levels = {1'b0, slash_next} + 5'd1;
                if (is_last) begin
                    res.last_of_packet = 1'b1;
                    if (tf_reg[7:4] == PKT_CONNACK) begin
                        res.connack_code     = rc_next;
                        res.connack_accepted = (rc_next == '0);
                    end else if (tf_reg[7:4] == PKT_PUBLISH) begin
                        res.publish_usable = (res.role == ROLE_PAYLOAD) &&
                                             (levels >= minl_reg);
                    end
                    phase_next = PH_HEADER;
                end else begin
                    pos_next = pos_inc[LEN_W-1:0];
                end
            end
            PH_HALT: begin
                res.role = ROLE_DROPPED;
            end
            default: begin
                phase_next = PH_HALT;
                res.role   = ROLE_DROPPED;
            end
        endcase

        if (phase_reg != PH_HALT) begin
            res.packet_type  = tf_next[7:4];
            res.header_flags = tf_next[3:0];
            res.topic_level  = (tf_next[7:4] == PKT_PUBLISH) ? slash_next : '0;
        end
        res.length_error = (phase_next == PH_HALT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            tf_reg    <= '0;
            len_reg   <= '0;
            lcnt_reg  <= '0;
            pos_reg   <= '0;
            tlen_reg  <= '0;
            slash_reg <= '0;
            rc_reg    <= RC_UNKNOWN;
        end else if (advance) begin
            phase_reg <= phase_next;
            tf_reg    <= tf_next;
            len_reg   <= len_next;
            lcnt_reg  <= lcnt_next;
            pos_reg   <= pos_next;
            tlen_reg  <= tlen_next;
            slash_reg <= slash_next;
            rc_reg    <= rc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minl_reg <= MIN_LEVELS_RESET;
        end else if (cfg_valid) begin
            minl_reg <= cfg_data;
        end
    end

endmodule
`default_nettype wire

### sv/mqd_out_stage.sv
// result register toward the tag output channel
`default_nettype none
module mqd_out_stage
    import mqd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t res_in,
    output logic         up_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign up_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign res_out  = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (up_ready) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule
`default_nettype wire

### sv/mqtt_packet_deframer.sv
// top level of the mqtt packet deframer
//
// channel   direction  handshake              word
// s_        in         s_valid / s_ready      s_rx_byte, one stream byte
// m_        out        m_valid / m_ready      byte tag and packet fields
// cfg_      in         cfg_valid / cfg_ready  cfg_data, min topic levels
//
// one byte per cycle sustained while m_ready stays high; a byte reaches m_
// through the input register, then decode into the result register
// aresetn is synchronous; reset clears the packet state and the sticky error
// a stall on m_ready holds the result register and backs up into s_ready
`default_nettype none
module mqtt_packet_deframer
    import mqd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_rx_byte,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MINL_W-1:0] cfg_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ROLE_W-1:0]      m_role,
    output logic [NIB_W-1:0]       m_packet_type,
    output logic [NIB_W-1:0]       m_header_flags,
    output logic [LEN_W-1:0]       m_body_length,
    output logic [LEN_W-1:0]       m_body_index,
    output logic [LVL_W-1:0]       m_topic_level,
    output logic                   m_last_of_packet,
    output logic                   m_publish_usable,
    output logic [BYTE_W-1:0]      m_connack_code,
    output logic                   m_connack_accepted,
    output logic                   m_length_error
);

    logic              down_ready;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              advance;
    result_t           res_dec;
    result_t           res_out;

    mqd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .down_ready (down_ready),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .advance    (advance)
    );

    mqd_decode u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .byte_data (byte_data),
        .res       (res_dec)
    );

    mqd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (byte_valid && down_ready),
        .res_in   (res_dec),
        .up_ready (down_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res_out  (res_out)
    );

    assign m_role             = res_out.role;
    assign m_packet_type      = res_out.packet_type;
    assign m_header_flags     = res_out.header_flags;
    assign m_body_length      = res_out.body_length;
    assign m_body_index       = res_out.body_index;
    assign m_topic_level      = res_out.topic_level;
    assign m_last_of_packet   = res_out.last_of_packet;
    assign m_publish_usable   = res_out.publish_usable;
    assign m_connack_code     = res_out.connack_code;
    assign m_connack_accepted = res_out.connack_accepted;
    assign m_length_error     = res_out.length_error;

endmodule
`default_nettype wire

### bench/mqtt_packet_deframer_test.sv
// stream test of the mqtt deframer: directed script, then paced random packets against a predictor
`timescale 1ns / 100ps
module mqtt_packet_deframer_test;
    import mqd_pkg::*;

    localparam int HALF_NS   = 4;
    localparam int LIMIT_NS  = 2_000_000;
    localparam int PHASE_LEN = 300;
    localparam int PRINT_CAP = 50;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              typed;
        result_t           want;
    } stim_row_t;

    localparam stim_row_t SCRIPT [26] = '{
        '{8'h20, 1'b1, '{role: ROLE_TYPE, packet_type: PKT_CONNACK, default: '0}},
        '{8'h00, 1'b1, '{role: ROLE_LENGTH, packet_type: PKT_CONNACK, last_of_packet: 1'b1,
                         connack_code: RC_UNKNOWN, default: '0}},
        '{8'h20, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{role: ROLE_OTHER, packet_type: PKT_CONNACK, body_length: 28'd2,
                         body_index: 28'd1, last_of_packet: 1'b1, connack_accepted: 1'b1,
                         default: '0}},
        '{8'h20, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'h3B, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h36, 1'b0, '0},
        '{8'h08, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h61, 1'b0, '0},
        '{8'h2F, 1'b0, '0},
        '{8'h62, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{8'h34, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h30, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'h78, 1'b0, '0}
    };

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MINL_W-1:0] cfg_data  = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [ROLE_W-1:0] m_role;
    logic [NIB_W-1:0]  m_packet_type;
    logic [NIB_W-1:0]  m_header_flags;
    logic [LEN_W-1:0]  m_body_length;
    logic [LEN_W-1:0]  m_body_index;
    logic [LVL_W-1:0]  m_topic_level;
    logic              m_last_of_packet;
    logic              m_publish_usable;
    logic [BYTE_W-1:0] m_connack_code;
    logic              m_connack_accepted;
    logic              m_length_error;

    // predictor state
    phase_t            dfr_phase  = PH_HEADER;
    logic [BYTE_W-1:0] hdr_byte   = '0;
    logic [LEN_W-1:0]  len_acc    = '0;
    logic [1:0]        len_groups = '0;
    logic [LEN_W-1:0]  body_pos   = '0;
    logic [TLEN_W-1:0] topic_len  = '0;
    logic [LVL_W-1:0]  slash_cnt  = '0;
    logic [BYTE_W-1:0] ret_code   = RC_UNKNOWN;
    logic [MINL_W-1:0] min_levels = MIN_LEVELS_RESET;

    result_t tag_q [$];
    int      fed           = 0;
    int      words_seen    = 0;
    int      mismatches    = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    bit      squeeze       = 1'b0;
    bit      squeezed_once = 1'b0;
    int      hold_left     = 0;

    mqtt_packet_deframer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_role            (m_role),
        .m_packet_type     (m_packet_type),
        .m_header_flags    (m_header_flags),
        .m_body_length     (m_body_length),
        .m_body_index      (m_body_index),
        .m_topic_level     (m_topic_level),
        .m_last_of_packet  (m_last_of_packet),
        .m_publish_usable  (m_publish_usable),
        .m_connack_code    (m_connack_code),
        .m_connack_accepted(m_connack_accepted),
        .m_length_error    (m_length_error)
    );

    always begin
        #HALF_NS aclk = 1'b1;
        #HALF_NS aclk = 1'b0;
    end

    initial begin
        #LIMIT_NS;
        $display("mqtt_packet_deframer_test NOT OK");
        $finish;
    end

    function automatic result_t deframe_step(input logic [BYTE_W-1:0] b);
        result_t          r;
        logic [NIB_W-1:0] kind;
        logic [LEN_W-1:0] pos;
        int unsigned      topic_end;
        int unsigned      id_end;
        r = '0;
        if (dfr_phase == PH_HALT) begin
            r.role = ROLE_DROPPED;
            r.length_error = 1'b1;
            return r;
        end
        unique case (dfr_phase)
            PH_HEADER: begin
                len_acc = '0;
                len_groups = '0;
                body_pos = '0;
                topic_len = '0;
                slash_cnt = '0;
                ret_code = RC_UNKNOWN;
                hdr_byte = b;
                dfr_phase = PH_LENGTH;
                r.role = ROLE_TYPE;
            end
            PH_LENGTH: begin
                r.role = ROLE_LENGTH;
                len_acc = len_acc | (LEN_W'(b[6:0]) << (7 * len_groups));
                r.body_length = len_acc;
                if (b[7]) begin
                    if (len_groups == 2'd3) begin
                        dfr_phase = PH_HALT;
                        r.length_error = 1'b1;
                    end else begin
                        len_groups = len_groups + 2'd1;
                    end
                end else if (len_acc == '0) begin
                    r.last_of_packet = 1'b1;
                    if (hdr_byte[7:4] == PKT_CONNACK) r.connack_code = RC_UNKNOWN;
                    dfr_phase = PH_HEADER;
                end else begin
                    body_pos = '0;
                    dfr_phase = PH_BODY;
                end
            end
            default: begin
                kind = hdr_byte[7:4];
                pos = body_pos;
                r.body_length = len_acc;
                r.body_index = pos;
                if (kind == PKT_PUBLISH) begin
                    topic_end = 2 + topic_len;
                    id_end = topic_end + ((hdr_byte[2:1] != 2'b00) ? 2 : 0);
                    if (pos == 0) begin
                        topic_len = {b, 8'h00};
                        r.role = ROLE_TOPIC_LEN;
                    end else if (pos == 1) begin
                        topic_len = {topic_len[15:8], b};
                        r.role = ROLE_TOPIC_LEN;
                    end else if (32'(pos) < topic_end) begin
                        r.role = ROLE_TOPIC;
                        if (b == SLASH_CHAR && slash_cnt < LVL_MAX) slash_cnt = slash_cnt + 1'b1;
                    end else if (32'(pos) < id_end) begin
                        r.role = ROLE_PKT_ID;
                    end else begin
                        r.role = ROLE_PAYLOAD;
                    end
                end else begin
                    r.role = ROLE_OTHER;
                    if (kind == PKT_CONNACK && pos == 1) ret_code = b;
                end
                if (32'(pos) + 1 >= 32'(len_acc)) begin
                    r.last_of_packet = 1'b1;
                    if (kind == PKT_CONNACK) begin
                        r.connack_code = ret_code;
                        r.connack_accepted = (ret_code == 8'h00);
                    end else if (kind == PKT_PUBLISH) begin
                        r.publish_usable = (r.role == ROLE_PAYLOAD)
                            && (32'(slash_cnt) + 1 >= 32'(min_levels));
                    end
                    dfr_phase = PH_HEADER;
                end else begin
                    body_pos = pos + 1'b1;
                end
            end
        endcase
        r.packet_type = hdr_byte[7:4];
        r.header_flags = hdr_byte[3:0];
        r.topic_level = (hdr_byte[7:4] == PKT_PUBLISH) ? slash_cnt : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t word %0d: %s got %0h want %0h", $realtime, words_seen, what, got, want);
    endtask

    task automatic compare_word(input result_t got, input result_t want);
        if (got.role !== want.role) report_mismatch("role", got.role, want.role);
        if (got.packet_type !== want.packet_type)
            report_mismatch("packet_type", got.packet_type, want.packet_type);
        if (got.header_flags !== want.header_flags)
            report_mismatch("header_flags", got.header_flags, want.header_flags);
        if (got.body_length !== want.body_length)
            report_mismatch("body_length", got.body_length, want.body_length);
        if (got.body_index !== want.body_index)
            report_mismatch("body_index", got.body_index, want.body_index);
        if (got.topic_level !== want.topic_level)
            report_mismatch("topic_level", got.topic_level, want.topic_level);
        if (got.last_of_packet !== want.last_of_packet)
            report_mismatch("last_of_packet", got.last_of_packet, want.last_of_packet);
        if (got.publish_usable !== want.publish_usable)
            report_mismatch("publish_usable", got.publish_usable, want.publish_usable);
        if (got.connack_code !== want.connack_code)
            report_mismatch("connack_code", got.connack_code, want.connack_code);
        if (got.connack_accepted !== want.connack_accepted)
            report_mismatch("connack_accepted", got.connack_accepted, want.connack_accepted);
        if (got.length_error !== want.length_error)
            report_mismatch("length_error", got.length_error, want.length_error);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed, input result_t want);
        result_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = deframe_step(b);
        tag_q.push_back(typed ? want : predicted);
        fed++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tag_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic emit_packet();
        logic [BYTE_W-1:0] body [$];
        logic [6:0]        grp [4];
        logic [BYTE_W-1:0] hdr;
        int unsigned       kind, tlen, plen, cut, v, w, ngrp, nlen, i;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            hdr = {PKT_PUBLISH, 4'($urandom_range(0, 15))};
            tlen = $urandom_range(0, 10);
            body.push_back(8'(tlen >> 8));
            body.push_back(8'(tlen));
            for (i = 0; i < tlen; i++) begin
                v = $urandom_range(0, 19);
                if (v < 6) body.push_back(SLASH_CHAR);
                else if (v == 6) body.push_back(8'($urandom));
                else body.push_back(8'h61 + 8'($urandom_range(0, 25)));
            end
            if (hdr[2:1] != 2'b00) repeat (2) body.push_back(8'($urandom));
            v = $urandom_range(0, 29);
            plen = (v < 3) ? 0 : (v == 3) ? $urandom_range(120, 200) : $urandom_range(1, 8);
            repeat (plen) body.push_back(8'($urandom));
            // broken publish: bad topic length or cut short
            if (kind >= 45) begin
                if (kind[0]) begin
                    body[0] = 8'($urandom);
                    body[1] = 8'($urandom);
                end else begin
                    cut = $urandom_range(1, body.size());
                    repeat (cut) void'(body.pop_back());
                end
            end
        end else if (kind < 75) begin
            hdr = {PKT_CONNACK, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0};
            v = $urandom_range(0, 5);
            plen = (v == 0) ? 0 : (v == 1) ? 1 : (v == 5) ? 3 : 2;
            for (i = 0; i < plen; i++) begin
                w = $urandom_range(0, 3);
                body.push_back((w < 2) ? 8'h00 : (w == 2) ? 8'($urandom_range(1, 5))
                                                         : 8'($urandom));
            end
        end else begin
            hdr = 8'($urandom);
            plen = $urandom_range(0, 6);
            repeat (plen) body.push_back(8'($urandom));
        end
        send_byte(hdr, 1'b0, '0);
        v = body.size();
        ngrp = 0;
        do begin
            grp[ngrp] = 7'(v);
            v = v >> 7;
            ngrp++;
        end while (v != 0);
        // sometimes pad the length with empty continuation groups
        nlen = ($urandom_range(0, 4) == 0) ? $urandom_range(ngrp, 4) : ngrp;
        for (i = 0; i < nlen; i++)
            send_byte({i < nlen - 1, (i < ngrp) ? grp[i] : 7'd0}, 1'b0, '0);
        foreach (body[k]) send_byte(body[k], 1'b0, '0);
    endtask

    task automatic traffic_phase(input int idle_pct, input int hold_pct,
                                 input logic [MINL_W-1:0] levels, input bit fill);
        int start;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= levels;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        min_levels = levels;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        squeeze = fill;
        start = fed;
        while (fed - start < PHASE_LEN) emit_packet();
        settle();
        squeeze = 1'b0;
    endtask

    // receiver pacing, with long hold-offs while squeezing
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (squeeze && (!squeezed_once || $urandom_range(0, 149) == 0)) begin
            squeezed_once = 1'b1;
            hold_left = $urandom_range(60, 120);
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : take_word
        result_t seen, want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_role, m_packet_type, m_header_flags, m_body_length, m_body_index,
                     m_topic_level, m_last_of_packet, m_publish_usable, m_connack_code,
                     m_connack_accepted, m_length_error};
            if (tag_q.size() == 0) begin
                report_mismatch("word with none pending", seen.role, 0);
            end else begin
                want = tag_q.pop_front();
                compare_word(seen, want);
            end
            words_seen++;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (SCRIPT[k]) send_byte(SCRIPT[k].data, SCRIPT[k].typed, SCRIPT[k].want);
        settle();

        traffic_phase(0, 0, 5'd1, 1'b0);
        traffic_phase(80, 0, 5'd16, 1'b0);
        traffic_phase(0, 80, 5'd0, 1'b0);
        traffic_phase(25, 25, 5'd31, 1'b0);
        traffic_phase(0, 0, 5'($urandom_range(1, 16)), 1'b1);

        // length overrun, then everything after is dropped
        send_idle_pct = 25;
        stall_pct = 25;
        send_byte({PKT_PUBLISH, 4'($urandom_range(0, 15))}, 1'b0, '0);
        repeat (4) send_byte(8'hFF, 1'b0, '0);
        repeat (20) send_byte(8'($urandom), 1'b0, '0);
        settle();

        if (tag_q.size() != 0) report_mismatch("words never seen", tag_q.size(), 0);
        if (mismatches == 0) begin
            $display("mqtt_packet_deframer_test OK");
        end else begin
            $display("mqtt_packet_deframer_test NOT OK");
        end
        $finish;
    end

endmodule

### mqtt_packet_deframer.f
sv/mqd_pkg.sv
sv/mqd_in_stage.sv
sv/mqd_decode.sv
sv/mqd_out_stage.sv
sv/mqtt_packet_deframer.sv
bench/mqtt_packet_deframer_test.sv
